FILE: rtl/core/mwpo_pkg.sv
// Shared types, constants and the sine table builder for the phase oscillator.
// Used by every module of the block; depends on nothing else.
package mwpo_pkg;

    // Build-time sizes of the oscillator.
    localparam int PHASE_BITS           = 32;
    localparam int SINE_TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS          = 16;

    // Stream and register widths.
    localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PHASE_STEP_W = 31;
    localparam int LEVEL_W      = 15;
    localparam int SHAPE_W      = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = PHASE_STEP_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SHAPE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_ENABLE = 2'd3;

    // Wave shape codes.
    localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd3;

    // Unit wave is Q15 in [-32768, 32768], so it needs 17 signed bits.
    localparam int WAVE_W = 17;
    localparam int PROD_W = WAVE_W + LEVEL_W + 1;
    localparam int ROUND_SH = 31 - SAMPLE_BITS;

    // Quarter-wave sine table.
    localparam int SINE_N      = 1 << SINE_TABLE_ADDR_BITS;
    localparam int SINE_DEPTH  = SINE_N + 1;
    localparam int SINE_ADDR_W = SINE_TABLE_ADDR_BITS + 1;
    localparam int SINE_W      = 16;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Reciprocals of the series divisors (2k)(2k+1), k = 1..7, scaled by
    // 2^RECIP_SH. The numerators stay below 2^34, so multiply and shift give
    // the exact floor quotient.
    localparam int RECIP_SH = 60;
    localparam longint unsigned TAYLOR_RECIP [7] = '{
        (64'd1 << RECIP_SH) / 64'd6   + 64'd1,
        (64'd1 << RECIP_SH) / 64'd20  + 64'd1,
        (64'd1 << RECIP_SH) / 64'd42  + 64'd1,
        (64'd1 << RECIP_SH) / 64'd72  + 64'd1,
        (64'd1 << RECIP_SH) / 64'd110 + 64'd1,
        (64'd1 << RECIP_SH) / 64'd156 + 64'd1,
        (64'd1 << RECIP_SH) / 64'd210 + 64'd1
    };

    typedef logic [SINE_W-1:0] sine_table_t [SINE_DEPTH];

    typedef struct packed {
        logic [PHASE_STEP_W-1:0] phase_step;
        logic [LEVEL_W-1:0]      level;
        logic [SHAPE_W-1:0]      wave_shape;
        logic                    wave_enable;
    } cfg_t;

    // Load enables of the four pipeline registers.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld_out;
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix;
        logic                          last;
        logic                          en;
        logic                          is_sine;
        logic                          sine_neg;
        logic [SINE_ADDR_W-1:0]        rom_addr;
        logic signed [WAVE_W-1:0]      wave;
    } stage1_t;

    // Sine in Q30 over [0, pi/2] by a Taylor series, rounded into Q15.
    // Evaluated only while the table constant is elaborated.
    function automatic sine_table_t build_sine_table();
        sine_table_t     tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        logic [127:0]    quot;
        longint          s;
        longint          v;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x    = (64'(i) * HALF_PI_Q30 + 64'(SINE_N >> 1)) >> SINE_TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                quot = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[k-1]);
                term = 64'(quot >> RECIP_SH);
                if (k[0]) begin
                    s = s - longint'(term);
                end else begin
                    s = s + longint'(term);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            v = (s + 64'sd16384) >>> 15;
            if (v > 64'sd32768) begin
                v = 64'sd32768;
            end
            tab[i] = SINE_W'(v);
        end
        return tab;
    endfunction

endpackage

FILE: rtl/core/mwpo_cfg_regs.sv
// Configuration register file of the phase oscillator.
// Depends on mwpo_pkg for register indexes and the cfg_t type.
module mwpo_cfg_regs
    import mwpo_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_PHASE_STEP:  cfg_next.phase_step  = cfg_wdata[PHASE_STEP_W-1:0];
                REG_LEVEL:       cfg_next.level       = cfg_wdata[LEVEL_W-1:0];
                REG_WAVE_SHAPE:  cfg_next.wave_shape  = cfg_wdata[SHAPE_W-1:0];
                REG_WAVE_ENABLE: cfg_next.wave_enable = cfg_wdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/mwpo_phase_acc.sv
// Phase accumulator and first pipeline stage: forms the unit wave for saw,
// square and triangle, and the sine table address. Depends on mwpo_pkg.
module mwpo_phase_acc
    import mwpo_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          ld1,
    input  logic signed [SAMPLE_BITS-1:0] mix_in,
    input  logic                          last_in,
    output stage1_t                       st1
);

    localparam logic signed [WAVE_W+1:0] W_ONE       = 19'sd32768;
    localparam logic signed [WAVE_W+1:0] W_THREE_HLF = 19'sd98304;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    stage1_t               st1_reg;
    stage1_t               st1_next;

    logic [15:0]                     u;
    logic                            first_half;
    logic [SINE_TABLE_ADDR_BITS+1:0] sine_top;
    logic [1:0]                      quad;
    logic [SINE_ADDR_W-1:0]          idx_ext;
    logic signed [WAVE_W+1:0]        u_ext;
    logic signed [WAVE_W+1:0]        wave_wide;

    always_comb begin
        u          = phase_reg[PHASE_BITS-1 -: 16];
        first_half = !u[15];
        sine_top   = phase_reg[PHASE_BITS-1 -: SINE_TABLE_ADDR_BITS + 2];
        quad       = sine_top[SINE_TABLE_ADDR_BITS+1:SINE_TABLE_ADDR_BITS];
        idx_ext    = {1'b0, sine_top[SINE_TABLE_ADDR_BITS-1:0]};
        u_ext      = $signed({3'b000, u});

        case (cfg.wave_shape)
            SHAPE_SAW:      wave_wide = W_ONE - u_ext;
            SHAPE_SQUARE:   wave_wide = first_half ? W_ONE : -W_ONE;
            SHAPE_TRIANGLE: wave_wide = first_half ? (u_ext <<< 1) - W_ONE
                                                   : W_THREE_HLF - (u_ext <<< 1);
            default:        wave_wide = '0;
        endcase

        st1_next.mix      = mix_in;
        st1_next.last     = last_in;
        st1_next.en       = cfg.wave_enable;
        st1_next.is_sine  = (cfg.wave_shape == SHAPE_SINE);
        st1_next.sine_neg = quad[1];
        // Odd quadrants read the table mirrored around the quarter turn.
        st1_next.rom_addr = quad[0] ? (SINE_ADDR_W'(SINE_N) - idx_ext) : idx_ext;
        st1_next.wave     = WAVE_W'(wave_wide);

        phase_next = phase_reg;
        if (ld1) begin
            phase_next = cfg.wave_enable ? phase_reg + PHASE_BITS'(cfg.phase_step) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            st1_reg <= st1_next;
        end
    end

    assign st1 = st1_reg;

endmodule

FILE: rtl/core/mwpo_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
// Contents come from the table builder in mwpo_pkg.
module mwpo_sine_rom
    import mwpo_pkg::*;
(
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [SINE_ADDR_W-1:0] rd_addr,
    output logic [SINE_W-1:0]      rd_data
);

    localparam sine_table_t SINE_ROM = build_sine_table();

    logic [SINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= SINE_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mwpo_scale_mix.sv
// Back end of the pipeline: selects the unit wave, scales it by the level,
// rounds, adds the mix sample, saturates if enabled. Depends on mwpo_pkg.
module mwpo_scale_mix
    import mwpo_pkg::*;
(
    input  logic                          aclk,
    input  pipe_ctrl_t                    ctrl,
    input  logic [LEVEL_W-1:0]            level,
    input  stage1_t                       st1,
    input  logic [SINE_W-1:0]             sine_val,
    output logic signed [SAMPLE_BITS-1:0] mix_out,
    output logic                          last_out
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (ROUND_SH - 1));
    localparam logic signed [PROD_W-1:0] SAT_MAX    = PROD_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MIN    = -SAT_MAX - PROD_W'(1);

    // Stage 2: alongside the ROM read.
    logic signed [SAMPLE_BITS-1:0] mix2_reg;
    logic                          last2_reg;
    logic                          en2_reg;
    logic                          is_sine2_reg;
    logic                          neg2_reg;
    logic signed [WAVE_W-1:0]      wave2_reg;

    // Stage 3: product.
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [SAMPLE_BITS-1:0] mix3_reg;
    logic                          last3_reg;
    logic                          en3_reg;

    // Output register.
    logic signed [SAMPLE_BITS-1:0] mix_out_reg;
    logic signed [SAMPLE_BITS-1:0] mix_out_next;
    logic                          last_out_reg;

    logic signed [WAVE_W-1:0] sine_s;
    logic signed [WAVE_W-1:0] wave_sel;
    logic signed [PROD_W-1:0] rounded;
    logic signed [PROD_W-1:0] sum;

    always_comb begin
        sine_s    = $signed({1'b0, sine_val});
        wave_sel  = is_sine2_reg ? (neg2_reg ? -sine_s : sine_s) : wave2_reg;
        prod_next = PROD_W'(wave_sel) * PROD_W'($signed({1'b0, level}));

        // Round half up from Q30 to the sample format, then saturate.
        rounded = (prod_reg + ROUND_HALF) >>> ROUND_SH;
        sum     = rounded + PROD_W'(mix3_reg);
        if (!en3_reg) begin
            mix_out_next = mix3_reg;
        end else if (sum > SAT_MAX) begin
            mix_out_next = SAMPLE_BITS'(SAT_MAX);
        end else if (sum < SAT_MIN) begin
            mix_out_next = SAMPLE_BITS'(SAT_MIN);
        end else begin
            mix_out_next = SAMPLE_BITS'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld2) begin
            mix2_reg     <= st1.mix;
            last2_reg    <= st1.last;
            en2_reg      <= st1.en;
            is_sine2_reg <= st1.is_sine;
            neg2_reg     <= st1.sine_neg;
            wave2_reg    <= st1.wave;
        end
        if (ctrl.ld3) begin
            prod_reg  <= prod_next;
            mix3_reg  <= mix2_reg;
            last3_reg <= last2_reg;
            en3_reg   <= en2_reg;
        end
        if (ctrl.ld_out) begin
            mix_out_reg  <= mix_out_next;
            last_out_reg <= last3_reg;
        end
    end

    assign mix_out  = mix_out_reg;
    assign last_out = last_out_reg;

endmodule

FILE: rtl/core/multi_waveform_phase_oscillator_top.sv
// Top level of the multi-waveform phase oscillator: pipeline control and
// instances of the config registers, phase stage, sine ROM and mixer.
// Depends on mwpo_pkg and the mwpo_* modules.
//
// Usage: each request on the s_ channel is one audio frame (mix sample in
// s_tdata, end of render block on s_tlast). Each frame yields exactly one
// request on the m_ channel carrying the mixed, saturated sample and a copy
// of tlast, in order. The oscillator is set up through the plain write port
// (phase step, level, wave shape, enable); the user must do so only while no
// frame is in flight; the block itself does not enforce this. Throughput
// is one frame per cycle while the receiver takes results. A frame passes
// the phase stage, registered sine ROM read, multiplier stage and output
// register in turn. Each stage has its own valid bit and accepts a new
// frame whenever it is empty or moving, so when the receiver stalls, the
// output register holds its result and up to three more frames are still
// taken before s_tready falls. Reset clears the configuration, the phase and
// all valid bits; the sine ROM is constant and needs no clearing.
module multi_waveform_phase_oscillator_top
    import mwpo_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] mix_in, rest zero
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // [SAMPLE_BITS-1:0] mix_out, rest zero
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t       cfg;
    pipe_ctrl_t ctrl;
    stage1_t    st1;

    logic [SINE_W-1:0]             sine_val;
    logic signed [SAMPLE_BITS-1:0] mix_out;
    logic                          last_out;

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic v1_next, v2_next, v3_next, vo_next;
    logic rdy1, rdy2, rdy3, rdy_o;

    always_comb begin
        rdy_o = !vo_reg || m_tready;
        rdy3  = !v3_reg || rdy_o;
        rdy2  = !v2_reg || rdy3;
        rdy1  = !v1_reg || rdy2;

        ctrl.ld1    = s_tvalid && rdy1;
        ctrl.ld2    = v1_reg && rdy2;
        ctrl.ld3    = v2_reg && rdy3;
        ctrl.ld_out = v3_reg && rdy_o;

        v1_next = ctrl.ld1 || (v1_reg && !ctrl.ld2);
        v2_next = ctrl.ld2 || (v2_reg && !ctrl.ld3);
        v3_next = ctrl.ld3 || (v3_reg && !ctrl.ld_out);
        vo_next = ctrl.ld_out || (vo_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    mwpo_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mwpo_phase_acc u_phase_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .ld1     (ctrl.ld1),
        .mix_in  ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .last_in (s_tlast),
        .st1     (st1)
    );

    mwpo_sine_rom u_sine_rom (
        .aclk    (aclk),
        .rd_en   (ctrl.ld2),
        .rd_addr (st1.rom_addr),
        .rd_data (sine_val)
    );

    mwpo_scale_mix u_scale_mix (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .level    (cfg.level),
        .st1      (st1),
        .sine_val (sine_val),
        .mix_out  (mix_out),
        .last_out (last_out)
    );

    assign s_tready = rdy1;
    assign m_tvalid = vo_reg;
    assign m_tdata  = TDATA_W'($unsigned(mix_out));
    assign m_tlast  = last_out;

endmodule

FILE: rtl/core/mwpo_checker.sv
// Port-level checks of the phase oscillator, bound to the top level.
// Depends on mwpo_pkg for the stream width.
module mwpo_checker
    import mwpo_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A receiver that takes results never backs up the input side.
    a_ready_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while the receiver is ready");

    // Without stalls a frame comes out of the pipeline with its own tlast.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && (m_tlast == $past(s_tlast, 4)))
        else $error("frame did not arrive after four unstalled cycles");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind multi_waveform_phase_oscillator_top mwpo_checker u_mwpo_checker (.*);
